/* rtl/core/kvne_pkg.sv */
// shared types, constants and helpers for the imu noise variance estimator
package kvne_pkg;

   localparam int AXES     = 6;
   localparam int AXIS_W   = 3;
   localparam int SAMPLE_W = 32;
   localparam int VAR_W    = 48;
   localparam int CNT_W    = 20;
   localparam int ALPHA_W  = 16;
   localparam int GAIN_W   = 33;
   localparam int MEM_W    = SAMPLE_W + 2 * VAR_W;
   localparam int CSR_IDX_W = 8;

   localparam logic [VAR_W-1:0]  VAR_MAX   = 48'hFFFF_FFFF_FFFF;
   localparam logic [VAR_W-1:0]  VAR_RESET = 48'd4294967;
   localparam logic [GAIN_W-1:0] GAIN_ONE  = 33'h1_0000_0000;

   localparam logic [VAR_W-1:0]   RST_PROCESS_NOISE     = 48'd4295;
   localparam logic [VAR_W-1:0]   RST_MEASUREMENT_NOISE = 48'd42950;
   localparam logic [VAR_W-1:0]   RST_VARIANCE_FLOOR    = 48'd43;
   localparam logic [CNT_W-1:0]   RST_WARMUP_COUNT      = 20'd1000;
   localparam logic [ALPHA_W-1:0] RST_MEAN_WEIGHT       = 16'd655;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_VARIANCE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VARIANCE_FLOOR    = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_COUNT      = 8'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_WEIGHT       = 8'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_MEAN,
      S_RES,
      S_DIV,
      S_MUL,
      S_WB,
      S_WAIT,
      S_DRAIN
   } kvne_state_type;

   typedef struct packed {
      logic              start;
      logic [VAR_W:0]    pp;
      logic [VAR_W+1:0]  den;
   } kvne_div_req_type;

   function automatic logic [VAR_W-1:0] clamp_var(input logic [VAR_W+3:0] x,
                                                  input logic [VAR_W-1:0] fl);
      logic [VAR_W-1:0] sat;
      sat = (x > {4'd0, VAR_MAX}) ? VAR_MAX : x[VAR_W-1:0];
      return (sat < fl) ? fl : sat;
   endfunction

endpackage

/* rtl/core/kalman_noise_variance_estimator.sv */
// top level of the imu noise variance estimator: per-axis kalman update over a state memory
//
// channel  dir  handshake             content
// req      in   req_tvalid/tready     tdata six samples, tuser stationary
// rsp      out  rsp_tvalid/tready     tdata six variances and count, tuser ready flag
// csr      in   csr_valid/csr_ready   csr_index register, csr_data value
//
// a stationary word runs the six axes in turn, each set by the gain division and six products
// through the shared multiplier, each in a low and a high half, then reads the six variances
// out of the memory; a gain that needs no division skips the divider's quotient loop
// a word that is not stationary skips the update and only reads the six variances out
// the next word is taken only once the readout for the last one is done
// reset is synchronous; no clearing pass, per-entry valid bits supply the reset state
// a new word is taken while the previous result waits; the readout waits for rsp to drain
module kalman_noise_variance_estimator (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [191:0]  req_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
   input  logic          req_tuser,   // stationary
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [311:0]  rsp_tdata,   // var_accel_x .. var_gyro_z, samples_counted, zero pad
   output logic          rsp_tuser,   // ready_res
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [kvne_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [47:0]   csr_data
);

   localparam int VW = kvne_pkg::VAR_W;
   localparam int SW = kvne_pkg::SAMPLE_W;

   kvne_pkg::kvne_state_type state_ff, state_in;

   logic [VW-1:0]                  q_ff, r_ff, floor_ff;
   logic [kvne_pkg::CNT_W-1:0]     warm_ff;
   logic [kvne_pkg::ALPHA_W-1:0]   alpha_ff;

   logic [191:0]                   data_ff, data_in;
   logic [kvne_pkg::AXIS_W-1:0]    axis_ff, axis_in;
   logic signed [SW-1:0]           mean_ff, mean_in;
   logic [VW-1:0]                  var_ff, var_in, cov_ff, cov_in, meas_ff, meas_in;
   logic [VW:0]                    pp_ff, pp_in;
   logic [2:0]                     op_ff, op_in;
   logic                           phase_ff, phase_in;
   logic [33:0]                    lo_ff, lo_in;
   logic [VW+2:0]                  t_ff, t_in;
   logic [VW+3:0]                  vacc_ff, vacc_in, pacc_ff, pacc_in;
   logic [kvne_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [2:0]                     drain_ff, drain_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                  rsp_var_ff [kvne_pkg::AXES];
   logic                           rsp_ready_res_ff;
   logic [kvne_pkg::CNT_W-1:0]     rsp_count_ff;

   logic [kvne_pkg::MEM_W-1:0]     state_mem [kvne_pkg::AXES];
   logic [kvne_pkg::AXES-1:0]      entry_valid_ff;
   logic [kvne_pkg::MEM_W-1:0]     rd_data_ff;
   logic                           rd_valid_ff;
   logic                           mem_rd_en, mem_wr_en;
   logic [kvne_pkg::AXIS_W-1:0]    mem_rd_addr;
   logic [kvne_pkg::MEM_W-1:0]     mem_wr_data;

   kvne_pkg::kvne_div_req_type     div_req;
   logic                           div_done;
   logic [kvne_pkg::GAIN_W-1:0]    gain;
   logic [kvne_pkg::GAIN_W-1:0]    jgain;

   logic [32:0]                    mul_a, mul_b;
   logic [65:0]                    mul_p;
   logic signed [SW-1:0]           sample;
   logic signed [SW:0]             diff;
   logic [SW-1:0]                  adiff;
   logic signed [49:0]             wsum;
   logic [49:0]                    mh_x;
   logic [kvne_pkg::GAIN_W-1:0]    mh_k;
   logic [VW+3:0]                  mh_res;
   logic [VW-1:0]                  var_new, cov_new;
   logic                           rsp_take, req_take;

   kvne_gain_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .gain     (gain)
   );

   assign req_tready = (state_ff == kvne_pkg::S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff     <= kvne_pkg::RST_PROCESS_NOISE;
         r_ff     <= kvne_pkg::RST_MEASUREMENT_NOISE;
         floor_ff <= kvne_pkg::RST_VARIANCE_FLOOR;
         warm_ff  <= kvne_pkg::RST_WARMUP_COUNT;
         alpha_ff <= kvne_pkg::RST_MEAN_WEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kvne_pkg::CSR_PROCESS_NOISE:     q_ff     <= csr_data;
            kvne_pkg::CSR_MEASUREMENT_NOISE: r_ff     <= csr_data;
            kvne_pkg::CSR_INITIAL_VARIANCE:  ;
            kvne_pkg::CSR_VARIANCE_FLOOR:    floor_ff <= csr_data;
            kvne_pkg::CSR_WARMUP_COUNT:      warm_ff  <= csr_data[kvne_pkg::CNT_W-1:0];
            kvne_pkg::CSR_MEAN_WEIGHT:       alpha_ff <= csr_data[kvne_pkg::ALPHA_W-1:0];
            default: ;
         endcase
      end
   end

   // shared datapath
   always_comb begin
      sample = data_ff[axis_ff*SW +: SW];
      diff   = {sample[SW-1], sample} - {mean_ff[SW-1], mean_ff};
      adiff  = diff[SW] ? SW'(-diff) : diff[SW-1:0];
      jgain  = kvne_pkg::GAIN_ONE - gain;
      case (op_ff)
         3'd0:    mh_x = {2'b00, var_ff};
         3'd1:    mh_x = {2'b00, meas_ff};
         3'd2:    mh_x = {1'b0, pp_ff};
         3'd4:    mh_x = {2'b00, r_ff};
         default: mh_x = t_ff[49:0];
      endcase
      mh_k = (op_ff == 3'd0 || op_ff == 3'd2 || op_ff == 3'd3) ? jgain : gain;
      case (state_ff)
         kvne_pkg::S_MEAN: begin
            mul_a = {17'd0, alpha_ff};
            mul_b = {1'b0, adiff};
         end
         kvne_pkg::S_RES: begin
            mul_a = {1'b0, adiff};
            mul_b = {1'b0, adiff};
         end
         default: begin
            mul_a = phase_ff ? {15'd0, mh_x[49:32]} : {1'b0, mh_x[31:0]};
            mul_b = mh_k;
         end
      endcase
      mul_p  = mul_a * mul_b;
      wsum   = {{2{mean_ff[SW-1]}}, mean_ff, 16'd0};
      wsum   = diff[SW] ? (wsum - $signed({2'b00, mul_p[47:0]}))
                        : (wsum + $signed({2'b00, mul_p[47:0]}));
      wsum   = wsum + 50'sd32768;
      mh_res = {18'd0, lo_ff} + {1'b0, mul_p[50:0]};
      var_new = kvne_pkg::clamp_var(vacc_ff, floor_ff);
      cov_new = kvne_pkg::clamp_var(pacc_ff, floor_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      data_in      = data_ff;
      axis_in      = axis_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      cov_in       = cov_ff;
      meas_in      = meas_ff;
      pp_in        = pp_ff;
      op_in        = op_ff;
      phase_in     = phase_ff;
      lo_in        = lo_ff;
      t_in         = t_ff;
      vacc_in      = vacc_ff;
      pacc_in      = pacc_ff;
      cnt_in       = cnt_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = axis_ff;
      mem_wr_en    = 1'b0;
      mem_wr_data  = {mean_ff, var_new, cov_new};
      div_req      = '0;
      unique case (state_ff)
         kvne_pkg::S_IDLE: begin
            if (req_take) begin
               data_in  = req_tdata;
               axis_in  = '0;
               state_in = req_tuser ? kvne_pkg::S_READ : kvne_pkg::S_WAIT;
            end
         end
         kvne_pkg::S_READ: begin
            mem_rd_en = 1'b1;
            state_in  = kvne_pkg::S_LOAD;
         end
         kvne_pkg::S_LOAD: begin
            mean_in  = rd_valid_ff ? rd_data_ff[127:96] : '0;
            var_in   = rd_valid_ff ? rd_data_ff[95:48] : kvne_pkg::VAR_RESET;
            cov_in   = rd_valid_ff ? rd_data_ff[47:0]  : kvne_pkg::VAR_RESET;
            state_in = kvne_pkg::S_MEAN;
         end
         kvne_pkg::S_MEAN: begin
            mean_in  = (cnt_ff == '0) ? sample : wsum[47:16];
            pp_in    = {1'b0, cov_ff} + {1'b0, q_ff};
            state_in = kvne_pkg::S_RES;
         end
         kvne_pkg::S_RES: begin
            meas_in      = (mul_p[63:48] != '0) ? kvne_pkg::VAR_MAX : mul_p[47:0];
            div_req.start = 1'b1;
            div_req.pp    = pp_ff;
            div_req.den   = {1'b0, pp_ff} + {2'b00, r_ff};
            state_in     = kvne_pkg::S_DIV;
         end
         kvne_pkg::S_DIV: begin
            if (div_done) begin
               op_in    = '0;
               phase_in = 1'b0;
               state_in = kvne_pkg::S_MUL;
            end
         end
         kvne_pkg::S_MUL: begin
            if (!phase_ff) begin
               lo_in    = mul_p[65:32];
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               op_in    = op_ff + 3'd1;
               case (op_ff)
                  3'd0:    vacc_in = mh_res;
                  3'd1:    vacc_in = vacc_ff + mh_res;
                  3'd3:    pacc_in = mh_res;
                  3'd5: begin
                     pacc_in  = pacc_ff + mh_res;
                     state_in = kvne_pkg::S_WB;
                  end
                  default: t_in = mh_res[VW+2:0];
               endcase
            end
         end
         kvne_pkg::S_WB: begin
            mem_wr_en = 1'b1;
            if (axis_ff == kvne_pkg::AXIS_W'(kvne_pkg::AXES - 1)) begin
               if (cnt_ff < warm_ff) begin
                  cnt_in = cnt_ff + 20'd1;
               end
               state_in = kvne_pkg::S_WAIT;
            end else begin
               axis_in  = axis_ff + 3'd1;
               state_in = kvne_pkg::S_READ;
            end
         end
         kvne_pkg::S_WAIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               drain_in = '0;
               state_in = kvne_pkg::S_DRAIN;
            end
         end
         kvne_pkg::S_DRAIN: begin
            mem_rd_en   = (drain_ff != 3'(kvne_pkg::AXES));
            mem_rd_addr = drain_ff;
            drain_in    = drain_ff + 3'd1;
            if (drain_ff == 3'(kvne_pkg::AXES)) begin
               rsp_valid_in = 1'b1;
               state_in     = kvne_pkg::S_IDLE;
            end
         end
         default: state_in = kvne_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kvne_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff  <= data_in;
      axis_ff  <= axis_in;
      mean_ff  <= mean_in;
      var_ff   <= var_in;
      cov_ff   <= cov_in;
      meas_ff  <= meas_in;
      pp_ff    <= pp_in;
      op_ff    <= op_in;
      phase_ff <= phase_in;
      lo_ff    <= lo_in;
      t_ff     <= t_in;
      vacc_ff  <= vacc_in;
      pacc_ff  <= pacc_in;
      drain_ff <= drain_in;
   end

   // result register, loaded from the memory readout
   always_ff @(posedge clock) begin
      if (state_ff == kvne_pkg::S_DRAIN && drain_ff != '0) begin
         rsp_var_ff[drain_ff - 3'd1] <= rd_valid_ff ? rd_data_ff[95:48] : kvne_pkg::VAR_RESET;
      end
      if (state_ff == kvne_pkg::S_DRAIN && drain_ff == 3'(kvne_pkg::AXES)) begin
         rsp_ready_res_ff <= (cnt_ff >= warm_ff);
         rsp_count_ff     <= cnt_ff;
      end
   end

   // per-axis state memory
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         state_mem[axis_ff] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= state_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (mem_wr_en) begin
            entry_valid_ff[axis_ff] <= 1'b1;
         end
         if (mem_rd_en) begin
            rd_valid_ff <= entry_valid_ff[mem_rd_addr];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ready_res_ff;
   assign rsp_tdata  = {4'd0, rsp_count_ff, rsp_var_ff[5], rsp_var_ff[4], rsp_var_ff[3],
                        rsp_var_ff[2], rsp_var_ff[1], rsp_var_ff[0]};

`ifndef ASSERT_OFF
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == kvne_pkg::S_DIV)
      else $error("divider finished outside the gain wait");

   a_last_axis: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kvne_pkg::S_WB && axis_ff == 3'(kvne_pkg::AXES - 1))
      |=> state_ff == kvne_pkg::S_WAIT)
      else $error("sequencer did not finish after the last axis");

   a_drain_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == kvne_pkg::S_DRAIN |-> !rsp_valid_ff)
      else $error("readout overwrote a pending result");

   a_cov_floor: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> mem_wr_data[47:0] >= floor_ff)
      else $error("covariance written below floor");
`endif

endmodule

/* rtl/core/kvne_gain_div.sv */
// restoring divider for the kalman gain, one quotient bit per cycle
module kvne_gain_div (
   input  logic                          clock,
   input  logic                          reset,
   input  kvne_pkg::kvne_div_req_type    div_req,
   output logic                          div_done,
   output logic [kvne_pkg::GAIN_W-1:0]   gain
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [kvne_pkg::VAR_W+2:0]   rem_ff, rem_in;
   logic [kvne_pkg::VAR_W+1:0]   den_ff, den_in;
   logic [30:0]                  quo_ff, quo_in;
   logic [kvne_pkg::GAIN_W-1:0]  gain_ff, gain_in;
   logic [kvne_pkg::VAR_W+2:0]   rem_sh;
   logic                         ge;

   always_comb begin
      rem_sh  = {rem_ff[kvne_pkg::VAR_W+1:0], 1'b0};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      gain_in = gain_ff;
      if (div_req.start) begin
         if (div_req.den == '0) begin
            gain_in = '0;
            done_in = 1'b1;
         end else if ({1'b0, div_req.pp} >= div_req.den) begin
            gain_in = kvne_pkg::GAIN_ONE;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            rem_in  = {2'b00, div_req.pp};
            den_in  = div_req.den;
            quo_in  = '0;
         end
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         quo_in = {quo_ff[29:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            gain_in = {1'b0, quo_ff, ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      gain_ff <= gain_in;
   end

   assign div_done = done_ff;
   assign gain     = gain_ff;

endmodule
